// ===== rtl/hcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcd_pkg
// types and constants shared by the collision search core, its checker and testbench
// ----------------------------------------------------------------------------
package hcd_pkg;

  // bucket count must stay a power of two: the bucket is the low key bits
  localparam int unsigned BUCKETS = 4096;
  localparam int unsigned WAYS    = 4;

  localparam int unsigned BKT_W   = $clog2(BUCKETS);
  localparam int unsigned FILL_W  = $clog2(WAYS + 1);
  localparam int unsigned EPOCH_W = 8;

  localparam int unsigned IN_W    = 32;
  localparam int unsigned IMG_W   = 31;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_COLLISION = 3'd1,
    ST_REPEATED  = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4,
    ST_FINISHED  = 3'd5
  } status_t;

  typedef enum logic {
    KIND_CLEAR = 1'b0,
    KIND_PROBE = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [IN_W-1:0]   candidate_input;
    logic [IN_W-1:0]   image_value;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [IN_W-1:0]   partner_input;
    logic [IMG_W-1:0]  masked_image;
  } out_word_t;

  // one bucket of the tried-input table
  typedef struct packed {
    logic [EPOCH_W-1:0]         epoch;
    logic [FILL_W-1:0]          fill;
    logic [WAYS-1:0][IN_W-1:0]  inputs;
  } tried_row_t;

  // one bucket of the image table
  typedef struct packed {
    logic [EPOCH_W-1:0]         epoch;
    logic [FILL_W-1:0]          fill;
    logic [WAYS-1:0][IMG_W-1:0] keys;
    logic [WAYS-1:0][IN_W-1:0]  owners;
  } image_row_t;

endpackage

// ===== rtl/hcd_ram.sv =====
// ----------------------------------------------------------------------------
// hcd_ram
// generic simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module hcd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/hash_collision_detector_core.sv =====
// ----------------------------------------------------------------------------
// hash_collision_detector_core
// collision search over two bucketed hash tables held in block memories
// ----------------------------------------------------------------------------
// Every word (probe or clear) is taken only in S_IDLE: the accept cycle reads
// the candidate's bucket row from the tried-input memory and the image's bucket
// row from the image memory. In S_READ the filled ways of both rows are checked,
// a stored probe writes its updated rows back and the result register is loaded;
// S_READ holds while the result register is full and stalled. The core cannot
// take a new word before the last one has loaded its result. The result register
// lets the next word be taken while a result is still waiting. Each row carries
// an epoch tag, so a clear only bumps the epoch; after reset, and after every
// 2**EPOCH_W-th clear when the epoch wraps, a clearing pass over all BUCKETS rows
// rewrites every row while no word is accepted.
module hash_collision_detector_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hcd_pkg::in_word_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output hcd_pkg::out_word_t out_word
);

  import hcd_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ
  } state_t;

  state_t             state_r, state_nxt;
  logic [BKT_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic               finished_r, finished_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  // latched word
  kind_t              kind_r;
  logic [IN_W-1:0]    cand_r;
  logic [IMG_W-1:0]   img_r;

  logic               accept;
  logic               out_free;
  logic               res_load;

  tried_row_t         t_rd, t_wr;
  image_row_t         i_rd, i_wr;
  logic               t_we, i_we;
  logic [BKT_W-1:0]   t_waddr, i_waddr;
  logic               store;

  logic [FILL_W-1:0]  tf, imf;
  logic               hit_t, hit_i;
  logic [IN_W-1:0]    partner;
  status_t            status;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign res_load = (state_r == S_READ) && out_free;

  hcd_ram #(
    .WIDTH ($bits(tried_row_t)),
    .DEPTH (BUCKETS)
  ) u_tried_ram (
    .clk     (clk),
    .wr_en   (t_we),
    .wr_addr (t_waddr),
    .wr_data (t_wr),
    .rd_en   (accept),
    .rd_addr (in_word.candidate_input[BKT_W-1:0]),
    .rd_data (t_rd)
  );

  hcd_ram #(
    .WIDTH ($bits(image_row_t)),
    .DEPTH (BUCKETS)
  ) u_image_ram (
    .clk     (clk),
    .wr_en   (i_we),
    .wr_addr (i_waddr),
    .wr_data (i_wr),
    .rd_en   (accept),
    .rd_addr (in_word.image_value[BKT_W-1:0]),
    .rd_data (i_rd)
  );

  // bucket lookup on the rows read in the accept cycle
  always_comb begin
    tf      = (t_rd.epoch == epoch_r) ? t_rd.fill : '0;
    imf     = (i_rd.epoch == epoch_r) ? i_rd.fill : '0;
    if (tf > FILL_W'(WAYS)) begin
      tf = FILL_W'(WAYS);
    end
    if (imf > FILL_W'(WAYS)) begin
      imf = FILL_W'(WAYS);
    end
    hit_t   = 1'b0;
    hit_i   = 1'b0;
    partner = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (FILL_W'(w) < tf && t_rd.inputs[w] == cand_r) begin
        hit_t = 1'b1;
      end
    end
    // downwards so that the lowest matching way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (FILL_W'(w) < imf && i_rd.keys[w] == img_r) begin
        hit_i   = 1'b1;
        partner = i_rd.owners[w];
      end
    end
  end

  always_comb begin
    status = ST_STORED;
    store  = 1'b0;
    priority if (kind_r == KIND_CLEAR) begin
      status = ST_CLEARED;
    end else if (finished_r) begin
      status = ST_FINISHED;
    end else if (hit_t) begin
      status = ST_REPEATED;
    end else if (hit_i) begin
      status = ST_COLLISION;
    end else if (tf >= FILL_W'(WAYS) || imf >= FILL_W'(WAYS)) begin
      status = ST_FULL;
    end else begin
      status = ST_STORED;
      store  = 1'b1;
    end
  end

  // write-back rows, or blank rows during the clearing pass
  always_comb begin
    t_wr       = t_rd;
    i_wr       = i_rd;
    t_wr.epoch = epoch_r;
    i_wr.epoch = epoch_r;
    t_wr.fill  = tf + FILL_W'(1);
    i_wr.fill  = imf + FILL_W'(1);
    for (int w = 0; w < WAYS; w++) begin
      if (FILL_W'(w) == tf) begin
        t_wr.inputs[w] = cand_r;
      end
      if (FILL_W'(w) == imf) begin
        i_wr.keys[w]   = img_r;
        i_wr.owners[w] = cand_r;
      end
    end
    t_we    = res_load && store;
    i_we    = res_load && store;
    t_waddr = cand_r[BKT_W-1:0];
    i_waddr = img_r[BKT_W-1:0];
    if (state_r == S_CLEAR) begin
      t_wr       = '0;
      i_wr       = '0;
      t_wr.epoch = epoch_r;
      i_wr.epoch = epoch_r;
      t_we       = 1'b1;
      i_we       = 1'b1;
      t_waddr    = clr_cnt_r;
      i_waddr    = clr_cnt_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    epoch_nxt     = epoch_r;
    finished_nxt  = finished_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + BKT_W'(1);
        if (clr_cnt_r == BKT_W'(BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_word_nxt.status        = status;
          out_word_nxt.partner_input = (status == ST_COLLISION) ? partner : '0;
          out_word_nxt.masked_image  = (status == ST_CLEARED) ? '0 : img_r;
          state_nxt                  = S_IDLE;
          if (status == ST_COLLISION) begin
            finished_nxt = 1'b1;
          end
          if (status == ST_CLEARED) begin
            finished_nxt = 1'b0;
            epoch_nxt    = epoch_r + EPOCH_W'(1);
            // epoch wraps: old tags could match again, so sweep the rows
            if (epoch_nxt == '0) begin
              state_nxt   = S_CLEAR;
              clr_cnt_nxt = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      epoch_r     <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      epoch_r     <= epoch_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_word_r <= out_word_nxt;
    if (accept) begin
      kind_r <= in_word.kind;
      cand_r <= in_word.candidate_input;
      img_r  <= in_word.image_value[IMG_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> in_stall)
    else $error("word accepted during clearing pass");

  a_collision_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && status == ST_COLLISION) |=> finished_r)
    else $error("collision did not finish the search");

  a_partner_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.status != ST_COLLISION) |-> (out_word_r.partner_input == '0))
    else $error("partner given without collision");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (t_we || i_we) |-> (state_r != S_IDLE))
    else $error("table write overlaps a bucket read");
`endif

endmodule

// ===== test/hash_collision_detector_checker.sv =====
// ----------------------------------------------------------------------------
// hash_collision_detector_checker
// watches both channels of the collision search core, keeps its own copy of
// the tried-input and image tables, predicts the outcome of every accepted
// word and compares each result word with the oldest outstanding prediction
// ----------------------------------------------------------------------------
module hash_collision_detector_checker
  import hcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_word,
  output int        fail_count,
  output int        pending_words
);

  localparam int unsigned SLOTS = BUCKETS * WAYS;

  logic [IMG_W-1:0] image_key_copy   [SLOTS];
  logic [IN_W-1:0]  image_owner_copy [SLOTS];
  logic [IN_W-1:0]  tried_copy       [SLOTS];
  int unsigned      image_used       [BUCKETS];
  int unsigned      tried_used       [BUCKETS];
  bit               search_done;

  out_word_t expected_outcomes [$];
  int        mismatches  = 0;
  int        reported    = 0;
  int        outstanding = 0;

  assign fail_count    = mismatches;
  assign pending_words = outstanding;

  function automatic void empty_tables();
    foreach (image_used[b]) image_used[b] = 0;
    foreach (tried_used[b]) tried_used[b] = 0;
    search_done = 1'b0;
  endfunction

  function automatic out_word_t search_outcome(in_word_t w);
    out_word_t        r;
    logic [IMG_W-1:0] img;
    int unsigned      tb;
    int unsigned      ib;
    int unsigned      tf;
    int unsigned      imf;
    int unsigned      slot;
    bit               hit;
    img             = w.image_value[IMG_W-1:0];
    r.status        = ST_STORED;
    r.partner_input = '0;
    r.masked_image  = img;
    hit             = 1'b0;
    slot            = 0;
    if (w.kind == KIND_CLEAR) begin
      empty_tables();
      r.status       = ST_CLEARED;
      r.masked_image = '0;
      return r;
    end
    if (search_done) begin
      r.status = ST_FINISHED;
      return r;
    end
    tb  = w.candidate_input % BUCKETS;
    ib  = img % BUCKETS;
    tf  = (tried_used[tb] > WAYS) ? WAYS : tried_used[tb];
    imf = (image_used[ib] > WAYS) ? WAYS : image_used[ib];
    for (int k = 0; k < tf; k++) begin
      if (tried_copy[tb * WAYS + k] == w.candidate_input) hit = 1'b1;
    end
    if (hit) begin
      r.status = ST_REPEATED;
      return r;
    end
    // first matching way wins, a full bucket does not hide a collision
    for (int k = 0; k < imf; k++) begin
      if (!hit && image_key_copy[ib * WAYS + k] == img) begin
        hit  = 1'b1;
        slot = ib * WAYS + k;
      end
    end
    if (hit) begin
      r.status        = ST_COLLISION;
      r.partner_input = image_owner_copy[slot];
      search_done     = 1'b1;
    end else if (tf >= WAYS || imf >= WAYS) begin
      r.status = ST_FULL;
    end else begin
      tried_copy[tb * WAYS + tf]        = w.candidate_input;
      tried_used[tb]                    = tf + 1;
      image_key_copy[ib * WAYS + imf]   = img;
      image_owner_copy[ib * WAYS + imf] = w.candidate_input;
      image_used[ib]                    = imf + 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      empty_tables();
      expected_outcomes.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (reported < 10) begin
            reported++;
            $display("unexpected result word: status %0d partner %h image %h",
                     out_word.status, out_word.partner_input, out_word.masked_image);
          end
        end else begin
          want = expected_outcomes.pop_front();
          if (out_word.status !== want.status ||
              out_word.partner_input !== want.partner_input ||
              out_word.masked_image !== want.masked_image) begin
            mismatches++;
            if (reported < 10) begin
              reported++;
              $display("mismatch: expected status %0d partner %h image %h,",
                       want.status, want.partner_input, want.masked_image,
                       " got status %0d partner %h image %h",
                       out_word.status, out_word.partner_input, out_word.masked_image);
            end
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        expected_outcomes.push_back(search_outcome(in_word));
      end
    end
    outstanding = expected_outcomes.size();
  end

endmodule

// ===== test/hash_collision_detector_core_tb.sv =====
// ----------------------------------------------------------------------------
// hash_collision_detector_core_tb
// drives clears and probes into the collision search core: a directed part
// for repeats, collisions, full buckets and probes after finish, then short
// random searches over small image pools with idle bursts on both sides, a
// long receiver hold-off and a full drain; the checker does the comparing
// ----------------------------------------------------------------------------
module hash_collision_detector_core_tb;
  import hcd_pkg::*;

  localparam int DIRECTED_ITEMS = 20;
  localparam int RANDOM_ITEMS   = 1350;
  localparam int HOLD_AT        = 400;
  localparam int PAUSE_AT       = 800;
  localparam int QUIET_TAIL     = 150;
  localparam int HOLD_CYCLES    = 300;
  localparam int CYCLE_LIMIT    = 400000;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  int fail_count;
  int pending_words;

  int items_sent  = 0;
  int send_run    = 0;
  int take_run    = 0;
  int cycle_count = 0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;
  bit quiet_tail  = 1'b0;
  bit drained     = 1'b0;

  logic [IN_W-1:0] used_cands [$];

  hash_collision_detector_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  hash_collision_detector_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic in_word_t clear_word();
    in_word_t w;
    w.kind            = KIND_CLEAR;
    w.candidate_input = $urandom;
    w.image_value     = $urandom;
    return w;
  endfunction

  function automatic in_word_t probe_word(logic [IN_W-1:0] cand, logic [IN_W-1:0] img);
    in_word_t w;
    w.kind            = KIND_PROBE;
    w.candidate_input = cand;
    w.image_value     = img;
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic put_word(input in_word_t w);
    if (items_sent == HOLD_AT && !hold_done) hold_req = 1'b1;
    quiet_tail = (items_sent >= DIRECTED_ITEMS + RANDOM_ITEMS - QUIET_TAIL);
    if (!quiet_tail) begin
      if (send_run == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        send_run = $urandom_range(0, 60);
      end else begin
        send_run--;
      end
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // one search: usually a clear, then probes over a small image pool, with
  // crowded buckets now and then so that full buckets show up
  task automatic run_search();
    logic [IN_W-1:0]  pool [$];
    logic [IN_W-1:0]  cand;
    logic [IN_W-1:0]  img;
    logic [BKT_W-1:0] cand_bkt;
    logic [BKT_W-1:0] img_bkt;
    int               probes;
    int               pool_n;
    bit               crowd_cand;
    bit               crowd_img;
    if ($urandom_range(0, 7) != 0) begin
      put_word(clear_word());
      used_cands.delete();
    end
    probes     = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 6);
    pool_n     = $urandom_range(1, 24);
    crowd_cand = ($urandom_range(0, 3) == 0);
    crowd_img  = ($urandom_range(0, 3) == 0);
    cand_bkt   = BKT_W'($urandom);
    img_bkt    = BKT_W'($urandom);
    repeat (pool_n) begin
      img = $urandom;
      if (crowd_img) img[BKT_W-1:0] = img_bkt;
      pool.push_back(img);
    end
    repeat (probes) begin
      if (used_cands.size() > 0 && $urandom_range(0, 5) == 0) begin
        cand = used_cands[$urandom_range(0, used_cands.size() - 1)];
      end else begin
        cand = $urandom;
        if (crowd_cand && $urandom_range(0, 1)) cand[BKT_W-1:0] = cand_bkt;
        used_cands.push_back(cand);
      end
      if ($urandom_range(0, 3) != 0) img = pool[$urandom_range(0, pool_n - 1)];
      else img = $urandom;
      // top bit is masked off inside, so flipping it must not matter
      if ($urandom_range(0, 1)) img[IN_W-1] = ~img[IN_W-1];
      put_word(probe_word(cand, img));
    end
  endtask

  // receiver: random stall bursts, one long hold-off, none at the tail
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!quiet_tail && take_run == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        take_run = $urandom_range(0, 60);
      end else begin
        out_stall <= 1'b0;
        if (take_run > 0) take_run--;
        @(negedge clk);
      end
    end
  end

  initial begin
    in_word_t w;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // straight after reset, no clear needed
    put_word(probe_word(32'h0000_0000, 32'h0000_0000));
    put_word(probe_word(32'hffff_ffff, 32'hffff_ffff));
    put_word(probe_word(32'h0000_0000, 32'h0000_0005));
    put_word(probe_word(32'h0000_0001, 32'h8000_0000));
    put_word(probe_word(32'h0000_0002, 32'h0000_0003));
    w = clear_word();
    w.candidate_input = '1;
    w.image_value     = '1;
    put_word(w);
    // tried bucket fills up on the fifth
    for (int k = 0; k < 5; k++) put_word(probe_word((k << 12) | 7, 32'h10 + k));
    // image bucket fills up on the fifth
    for (int k = 0; k < 5; k++) begin
      put_word(probe_word(32'h100 + k, (k << 12) | 32'h55 | ((k % 2) ? 32'h8000_0000 : 0)));
    end
    // repeat in a full tried bucket, then a collision in a full image bucket
    put_word(probe_word(32'h0000_2007, 32'h0000_0999));
    put_word(probe_word(32'h0000_0200, 32'h8000_2055));
    put_word(clear_word());
    put_word(probe_word(32'h0000_0100, 32'h0000_0055));

    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      if (!drained && items_sent >= PAUSE_AT) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_words != 0);
      end
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(2, 10)) put_word(clear_word());
      end
      run_search();
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending_words != 0);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
